/* hdl/tpl_pkg.sv */
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types and constants for the two-party lock table.
// ----------------------------------------------------------------------------
package tpl_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int ACTION_W      = 3;
    localparam int ID_W          = 5;
    localparam int ROLE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int AID_W         = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE  = 3'd0,
        ACT_ACQUIRE = 3'd1,
        ACT_POLL    = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_DESTROY = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_WAIT    = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } tpl_cmd_t;

endpackage

/* hdl/tpl_ctrl.sv */
// ----------------------------------------------------------------------------
// tpl_ctrl
// Sequencer: takes one request beat, runs it through the datapath and holds
// the result beat until it is taken.
// ----------------------------------------------------------------------------
module tpl_ctrl
    import tpl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output tpl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/tpl_datapath.sv */
// ----------------------------------------------------------------------------
// tpl_datapath
// Lock slot storage, free slot search, request decode and result register.
// ----------------------------------------------------------------------------
module tpl_datapath
    import tpl_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpl_cmd_t            cmd,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ID_W-1:0]     s_lock_id,
    input  logic [ROLE_W-1:0]   s_role,
    output logic [STATUS_W-1:0] m_status,
    output logic [AID_W-1:0]    m_assigned_id
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [ID_W:0] SLOTS_CMP = (ID_W+1)'(NUM_SLOTS);

    logic [ACTION_W-1:0] action_reg;
    logic [ID_W-1:0]     id_reg;
    logic [ROLE_W-1:0]   role_reg;

    logic [NUM_SLOTS-1:0] used_reg;
    logic [NUM_SLOTS-1:0] turn_reg;
    logic [1:0]           flags_reg [NUM_SLOTS];

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [AID_W-1:0]    aid_reg;
    logic [AID_W-1:0]    aid_next;

    logic              in_range;
    logic [SLOT_W-1:0] slot;
    logic              id_ok;
    logic              role_ok;
    logic              r;
    logic [1:0]        cur_flags;
    logic              cur_turn;

    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [ID_W-1:0]   free_id;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_used;
    logic [1:0]        wr_flags;
    logic              wr_turn_en;
    logic              wr_turn;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= s_action;
            id_reg     <= s_lock_id;
            role_reg   <= s_role;
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        free_id    = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
                free_id    = ID_W'(i);
            end
        end
    end

    assign in_range  = {1'b0, id_reg} < SLOTS_CMP;
    assign slot      = in_range ? id_reg[SLOT_W-1:0] : '0;
    assign id_ok     = in_range && used_reg[slot];
    assign role_ok   = (role_reg[1] == 1'b0);
    assign r         = role_reg[0];
    assign cur_flags = flags_reg[slot];
    assign cur_turn  = turn_reg[slot];

    always_comb begin
        status_next = STAT_INVALID;
        aid_next    = '0;
        wr_en       = 1'b0;
        wr_slot     = slot;
        wr_used     = 1'b1;
        wr_flags    = cur_flags;
        wr_turn_en  = 1'b0;
        wr_turn     = 1'b0;
        case (action_reg)
            ACT_CREATE: begin
                status_next = STAT_FULL;
                if (free_found) begin
                    status_next = STAT_OK;
                    aid_next    = free_id[AID_W-1:0];
                    wr_en       = 1'b1;
                    wr_slot     = free_slot;
                    wr_flags    = 2'b00;
                    wr_turn_en  = 1'b1;
                end
            end
            ACT_ACQUIRE: begin
                if (id_ok && role_ok) begin
                    wr_en       = 1'b1;
                    wr_flags    = cur_flags | (r ? 2'b10 : 2'b01);
                    wr_turn_en  = 1'b1;
                    wr_turn     = r;
                    // other flag is untouched and turn now equals the caller
                    status_next = cur_flags[~r] ? STAT_WAIT : STAT_OK;
                end
            end
            ACT_POLL: begin
                if (id_ok && role_ok) begin
                    status_next = (cur_flags[~r] && (cur_turn == r)) ? STAT_WAIT : STAT_OK;
                end
            end
            ACT_RELEASE: begin
                if (id_ok && role_ok) begin
                    wr_en       = 1'b1;
                    wr_flags    = cur_flags & (r ? 2'b01 : 2'b10);
                    status_next = STAT_OK;
                end
            end
            ACT_DESTROY: begin
                if (id_ok) begin
                    wr_en       = 1'b1;
                    wr_used     = 1'b0;
                    wr_flags    = 2'b00;
                    status_next = STAT_OK;
                end
            end
            default: begin
                status_next = STAT_INVALID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            turn_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                flags_reg[i] <= 2'b00;
            end
        end else if (cmd.exec && wr_en) begin
            used_reg[wr_slot]  <= wr_used;
            flags_reg[wr_slot] <= wr_flags;
            if (wr_turn_en) begin
                turn_reg[wr_slot] <= wr_turn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            aid_reg    <= aid_next;
        end
    end

    assign m_status      = status_reg;
    assign m_assigned_id = aid_reg;

endmodule

/* hdl/two_party_lock_table_top.sv */
// ----------------------------------------------------------------------------
// two_party_lock_table_top
// Table of two-party Peterson locks: create, acquire, poll, release, destroy.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  s_      | s_valid s_ready s_action s_lock_id s_role | request in
//  m_      | m_valid m_ready m_status m_assigned_id  | result out
//
//  one request beat is in flight at a time: accept, execute, then the result
//  beat is held until taken, so a new request waits until the result is taken
//  the execute cycle reads and writes one slot and runs the free slot search
//  synchronous active-low reset clears all slots and returns to accepting
//  a stalled result beat holds s_ready low
module two_party_lock_table_top
    import tpl_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [ID_W-1:0]     s_lock_id,
    input  logic [ROLE_W-1:0]   s_role,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [AID_W-1:0]    m_assigned_id
);

    tpl_cmd_t cmd;

    tpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tpl_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_action      (s_action),
        .s_lock_id     (s_lock_id),
        .s_role        (s_role),
        .m_status      (m_status),
        .m_assigned_id (m_assigned_id)
    );

endmodule

/* hdl/tpl_checker.sv */
// ----------------------------------------------------------------------------
// tpl_checker
// Port-level checks for the two-party lock table.
// ----------------------------------------------------------------------------
module tpl_checker
    import tpl_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [ACTION_W-1:0] s_action,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [AID_W-1:0]    m_assigned_id
);

    // held result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_assigned_id))
        else $error("result beat changed while stalled");

    // one beat in flight
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken back to back");

    // only a successful create carries an id
    a_aid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> m_assigned_id == '0)
        else $error("id on a non-ok result");

    // unknown action is rejected
    a_bad_act: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action > ACT_DESTROY)
        |-> ##2 (m_valid && (m_status == STAT_INVALID)))
        else $error("unknown action not rejected");

endmodule

bind two_party_lock_table_top tpl_checker u_tpl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_assigned_id (m_assigned_id)
);
